/* hdl/dchpg_pkg.sv */
package dchpg_pkg;

    // Fixed field widths of the sample and result words.
    localparam int SAMPLE_BITS   = 16;
    localparam int PEAK_BITS     = SAMPLE_BITS - 1;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register widths and reset values.
    localparam int GAIN_W     = 5;
    localparam int ALPHA_W    = 16;
    localparam int ALPHA_FRAC = 16;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 5'd4;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd1311;

    // APB register map: one register per 32-bit word.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          new_recording;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_sample;
        logic [PEAK_BITS-1:0]          peak_level;
    } out_word_t;

endpackage

/* hdl/dchpg_mul_unit.sv */
module dchpg_mul_unit import dchpg_pkg::*; #(
    parameter int A_W = 33,
    parameter int B_W = 17
) (
    input  logic                      aclk,
    input  logic                      mul_en,
    input  logic signed [A_W-1:0]     op_a,
    input  logic signed [B_W-1:0]     op_b,
    output logic signed [A_W+B_W-1:0] product
);

    // Shared signed multiplier; the product is registered so that the
    // sequencer reads it in the state after the one that issues the operands.
    logic signed [A_W+B_W-1:0] product_reg;
    logic signed [A_W+B_W-1:0] product_next;

    assign product_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

/* hdl/dc_tracking_highpass_gain_peak.sv */
// DC-blocking high-pass filter with integer gain and peak hold.
//
// Sample words enter on the s_ channel (valid/ready) and each one yields
// exactly one result word on the m_ channel: the DC-removed, amplified and
// saturated sample together with the peak absolute output seen since the
// current recording started. Gain and the tracking coefficient alpha are set
// through the APB port (gain at 0x0, alpha at 0x4). The user must write them
// only while the block is idle; the block itself does not enforce this. Each
// word passes twice through a single shared multiplier (once for the alpha
// update of the DC estimate, once for the gain) with an add step and a
// truncate/saturate step around them: states multiply-alpha, update,
// multiply-gain and finish, where the result is registered once the output
// register is free. The sequencer takes a new word only when back in idle.
//
// Reset is synchronous and active low. It restores gain to 4, alpha to 1311,
// clears the estimate, the peak and the seeded flag, and empties the result
// register. A stalled receiver holds the result in the output register; the
// block may still accept the next word and compute it, but will not overwrite
// the waiting result until it has been taken.
module dc_tracking_highpass_gain_peak import dchpg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Sample channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // The estimate is a signed fixed-point value with FRAC_BITS fraction bits.
    localparam int EST_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int OPA_W  = EST_W + 1;
    localparam int OPB_W  = ALPHA_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int Y_W    = PROD_W - FRAC_BITS;

    localparam logic signed [Y_W-1:0] Y_MAX =
        {{(Y_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN =
        {{(Y_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PEAK_BITS-1:0] PEAK_MAX = {PEAK_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ALPHA,
        ST_UPDATE,
        ST_MUL_GAIN,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic signed [EST_W-1:0]  est_reg;
    logic                     seeded_reg;
    logic [PEAK_BITS-1:0]     peak_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                     m_valid_reg;
    out_word_t                m_data_reg;

    logic                     in_fire;
    logic                     cfg_write;
    logic signed [EST_W-1:0]  xf;
    logic signed [EST_W-1:0]  xf_in;
    logic signed [OPA_W-1:0]  diff;
    logic signed [OPB_W-1:0]  op_b;
    logic                     mul_en;
    logic signed [PROD_W-1:0] prod;
    logic signed [EST_W+1:0]  est_sum;
    logic signed [PROD_W-1:0] ac_biased;
    logic signed [Y_W-1:0]    y_wide;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [SAMPLE_BITS-1:0] y_neg;
    logic [PEAK_BITS-1:0]     mag;
    logic                     out_free;

    assign in_fire   = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // Sample scaled into the estimate's fixed-point format.
    assign xf    = {sample_reg, {FRAC_BITS{1'b0}}};
    assign xf_in = {s_data.sample, {FRAC_BITS{1'b0}}};

    // Distance of the sample from the current estimate; feeds both passes.
    assign diff = {xf[EST_W-1], xf} - {est_reg[EST_W-1], est_reg};

    always_comb begin
        unique case (state_reg)
            ST_MUL_GAIN: op_b = {{(OPB_W-GAIN_W){1'b0}}, gain_reg};
            default:     op_b = {1'b0, alpha_reg};
        endcase
    end

    assign mul_en = (state_reg == ST_MUL_ALPHA) || (state_reg == ST_MUL_GAIN);

    dchpg_mul_unit #(
        .A_W (OPA_W),
        .B_W (OPB_W)
    ) u_mul (
        .aclk    (aclk),
        .mul_en  (mul_en),
        .op_a    (diff),
        .op_b    (op_b),
        .product (prod)
    );

    // The alpha step: dropping the low bits of the product is a floor, which
    // matches an arithmetic shift. The result always lies between the old
    // estimate and the sample, so it fits the estimate width.
    assign est_sum = {{2{est_reg[EST_W-1]}}, est_reg} + prod[PROD_W-1:ALPHA_FRAC];

    // The gain step truncates toward zero: negative products get a bias of
    // all ones below the binary point before the low bits are dropped.
    assign ac_biased = prod + (prod[PROD_W-1] ?
        {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0);
    assign y_wide = ac_biased[PROD_W-1:FRAC_BITS];

    always_comb begin
        priority if (y_wide > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (y_wide < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_wide[SAMPLE_BITS-1:0];
        end
    end

    // Absolute value for the peak; the most negative sample maps to the
    // largest positive one.
    assign y_neg = -y_sat;
    always_comb begin
        priority if (y_sat == SMP_MIN) begin
            mag = PEAK_MAX;
        end else if (y_sat[SAMPLE_BITS-1]) begin
            mag = y_neg[PEAK_BITS-1:0];
        end else begin
            mag = y_sat[PEAK_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_RESET;
            alpha_reg   <= ALPHA_RESET;
            est_reg     <= '0;
            seeded_reg  <= 1'b0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                    REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                    default:   gain_reg  <= gain_reg;
                endcase
            end

            // In the finish step the result register is reloaded instead.
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        sample_reg <= s_data.sample;
                        // A new recording (or the first word) seeds the
                        // estimate with the sample itself and clears the peak.
                        if (!seeded_reg || s_data.new_recording) begin
                            est_reg    <= xf_in;
                            peak_reg   <= '0;
                            seeded_reg <= 1'b1;
                        end
                        state_reg <= ST_MUL_ALPHA;
                    end
                end
                ST_MUL_ALPHA: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    est_reg   <= est_sum[EST_W-1:0];
                    state_reg <= ST_MUL_GAIN;
                end
                ST_MUL_GAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.filtered_sample <= y_sat;
                        if (mag > peak_reg) begin
                            peak_reg              <= mag;
                            m_data_reg.peak_level <= mag;
                        end else begin
                            m_data_reg.peak_level <= peak_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Register read-back and an always-ready APB port.
    always_comb begin
        unique case (paddr[2])
            REG_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, gain_reg};
            REG_ALPHA: prdata = {{(PDATA_W-ALPHA_W){1'b0}}, alpha_reg};
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

endmodule

/* hdl/dchpg_checker.sv */
module dchpg_checker import dchpg_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic signed [SAMPLE_BITS-1:0] out_neg;
    logic [SAMPLE_BITS-1:0]        out_mag;

    assign out_neg = -m_data.filtered_sample;
    assign out_mag = m_data.filtered_sample[SAMPLE_BITS-1] ?
        ((m_data.filtered_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ?
            {1'b0, {(SAMPLE_BITS-1){1'b1}}} : out_neg) : m_data.filtered_sample;

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous word still in progress");

    // A waiting result is neither dropped nor altered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or vanished");

    // The reported peak covers the sample it is reported with.
    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.peak_level} >= out_mag))
        else $error("peak level below current output magnitude");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind dc_tracking_highpass_gain_peak dchpg_checker u_dchpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
